// ===== rtl/efs_pkg.sv =====
// Shared types and constants of the even-first sorter.
// No dependencies; every other file imports this package.
package efs_pkg;

    // Port width of a value word and the width actually kept.
    localparam int DATA_W       = 16;
    localparam int VALUE_WIDTH  = 16;

    // Capacity of the sorting chain.
    localparam int MAX_ELEMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // One classified word passed from the front to the back.
    typedef struct packed {
        value_t value;
        logic   last;  // closes the set and starts the drain
        logic   keep;  // value fits in the chain and is inserted
    } efs_entry_t;

    // Sort key: the low bit first, then the value itself.
    function automatic logic [VALUE_WIDTH:0] order_key(input value_t v);
        order_key = {v[0], v};
    endfunction

endpackage

// ===== rtl/efs_in_if.sv =====
// Input channel of the even-first sorter: valid/ready plus payload.
// Depends on efs_pkg for the port width.
interface efs_in_if
    import efs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic              is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

// ===== rtl/efs_out_if.sv =====
// Output channel of the even-first sorter: valid/ready plus payload.
// Depends on efs_pkg for the port width.
interface efs_out_if
    import efs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value_res;
    logic              is_last_res;

    modport source (output valid, output value_res, output is_last_res, input ready);
    modport sink   (input valid, input value_res, input is_last_res, output ready);
endinterface

// ===== rtl/efs_front.sv =====
// Front end: accepts input words, counts the set and marks words that fit.
// Depends on efs_pkg and efs_in_if.
module efs_front
    import efs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    efs_in_if.sink     in_ch,
    output logic       push_valid,
    output efs_entry_t push_entry,
    input  logic       push_ready
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             fits;
    logic             accept;

    // A word is taken whenever the queue has room.
    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign fits        = (count_reg < CNT_W'(MAX_ELEMENTS));

    // Words beyond capacity are dropped unless they close the set.
    always_comb
    begin
        push_entry.value = VALUE_WIDTH'(in_ch.value);
        push_entry.last  = in_ch.is_last;
        push_entry.keep  = fits;
        push_valid       = accept && (fits || in_ch.is_last);
    end

    // Count of values held for the current set.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (in_ch.is_last)
            begin
                count_next = '0;
            end
            else if (fits)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/efs_queue.sv =====
// Short first-in first-out queue between the front and the back.
// Depends on efs_pkg.
module efs_queue
    import efs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  efs_entry_t push_entry,
    output logic       push_ready,
    output logic       pop_valid,
    output efs_entry_t pop_entry,
    input  logic       pop_ready
);

    efs_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/efs_back.sv =====
// Back end: insertion chain that keeps the set sorted, then drains it.
// Depends on efs_pkg and efs_out_if.
module efs_back
    import efs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  efs_entry_t pop_entry,
    output logic       pop_ready,
    efs_out_if.source  out_ch
);

    value_t                  cell_val_reg  [MAX_ELEMENTS];
    value_t                  cell_val_next [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] cell_vld_reg;
    logic [MAX_ELEMENTS-1:0] cell_vld_next;
    logic [MAX_ELEMENTS-1:0] above;
    logic                    drain_reg;
    logic                    drain_next;
    logic                    out_vld_reg;
    logic                    out_vld_next;
    value_t                  out_val_reg;
    value_t                  out_val_next;
    logic                    out_last_reg;
    logic                    out_last_next;
    logic                    insert;
    logic                    move;

    // The chain takes no new word while it is draining.
    assign pop_ready = !drain_reg;
    assign insert    = pop_valid && !drain_reg && pop_entry.keep;
    assign move      = drain_reg && (!out_vld_reg || out_ch.ready);

    // Each cell compares its own key with the incoming one.
    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            above[i] = !cell_vld_reg[i] ||
                       (order_key(cell_val_reg[i]) > order_key(pop_entry.value));
        end
    end

    // Next chain contents: insert in place, shift down on drain, or hold.
    always_comb
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            cell_val_next[i] = cell_val_reg[i];
            cell_vld_next[i] = cell_vld_reg[i];
            if (insert)
            begin
                if (above[i])
                begin
                    if (i > 0 && above[(i > 0) ? i - 1 : 0])
                    begin
                        cell_val_next[i] = cell_val_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        cell_val_next[i] = pop_entry.value;
                    end
                end
                cell_vld_next[i] = (i == 0) ? 1'b1 : cell_vld_reg[(i > 0) ? i - 1 : 0];
            end
            else if (move)
            begin
                if (i < MAX_ELEMENTS - 1)
                begin
                    cell_val_next[i] = cell_val_reg[(i < MAX_ELEMENTS - 1) ? i + 1 : i];
                    cell_vld_next[i] = cell_vld_reg[(i < MAX_ELEMENTS - 1) ? i + 1 : i];
                end
                else
                begin
                    cell_vld_next[i] = 1'b0;
                end
            end
        end
    end

    // Drain control and output register.
    always_comb
    begin
        drain_next    = drain_reg;
        out_vld_next  = out_vld_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        if (pop_valid && !drain_reg && pop_entry.last)
        begin
            drain_next = 1'b1;
        end
        if (move)
        begin
            out_vld_next  = 1'b1;
            out_val_next  = cell_val_reg[0];
            out_last_next = !cell_vld_reg[1];
            if (!cell_vld_reg[1])
            begin
                drain_next = 1'b0;
            end
        end
        else if (out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_vld_reg <= '0;
            drain_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            cell_vld_reg <= cell_vld_next;
            drain_reg    <= drain_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            cell_val_reg[i] <= cell_val_next[i];
        end
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.value_res   = DATA_W'(out_val_reg);
    assign out_ch.is_last_res = out_last_reg;

endmodule

// ===== rtl/even_first_sorter_top.sv =====
// Even-first sorter: on the closing word emits the set with even values ascending,
// then odd values ascending. Throughput: one input word per cycle while the queue
// has room, one result word per cycle while the receiver is ready. The closing
// word passes the queue and sets the drain flag. While a set drains, the front
// keeps accepting until the four-entry queue fills. Reset (rst_n low, asynchronous)
// empties the queue, the chain and the output register.
module even_first_sorter_top
    import efs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    efs_in_if.sink    in_ch,
    efs_out_if.source out_ch
);

    logic       push_valid;
    efs_entry_t push_entry;
    logic       push_ready;
    logic       pop_valid;
    efs_entry_t pop_entry;
    logic       pop_ready;

    // Classify incoming words.
    efs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // Decouple front and back.
    efs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // Sort and emit.
    efs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule

// ===== bench/even_first_sorter_top_tb.sv =====
// Self-checking bench for the even-first sorter: a directed table of sets,
// then random sets, checked against an in-bench sorting predictor or a row's want.
// Depends on efs_pkg and the efs_in_if / efs_out_if channel interfaces.
module even_first_sorter_top_tb
    import efs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 336;
    localparam int QUIET_TAIL    = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 10;
    localparam int DIR_ROWS      = 24;

    // One word of a sorted burst.
    typedef struct packed {
        value_t value;
        logic   last;
    } sorted_word_t;

    // One row of the directed table; typed rows are lone sets whose single
    // result is written down directly.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              typed;
        value_t            want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    efs_in_if  in_ch ();
    efs_out_if out_ch ();

    even_first_sorter_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Directed sets: lone extremes after reset, mixed parity, duplicates,
    // reversed odds, unordered evens, alternating bit patterns.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{16'h0000, 1'b1, 1'b1, 16'h0000},
        '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
        '{16'h0001, 1'b1, 1'b1, 16'h0001},
        '{16'hFFFE, 1'b1, 1'b1, 16'hFFFE},
        '{16'h0009, 1'b0, 1'b0, 16'h0000},
        '{16'h0002, 1'b0, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{16'h0000, 1'b0, 1'b0, 16'h0000},
        '{16'h0008, 1'b0, 1'b0, 16'h0000},
        '{16'h0001, 1'b0, 1'b0, 16'h0000},
        '{16'h0002, 1'b1, 1'b0, 16'h0000},
        '{16'h0005, 1'b0, 1'b0, 16'h0000},
        '{16'h0006, 1'b0, 1'b0, 16'h0000},
        '{16'h0005, 1'b0, 1'b0, 16'h0000},
        '{16'h0006, 1'b1, 1'b0, 16'h0000},
        '{16'h0007, 1'b0, 1'b0, 16'h0000},
        '{16'h0005, 1'b0, 1'b0, 16'h0000},
        '{16'h0003, 1'b0, 1'b0, 16'h0000},
        '{16'h0001, 1'b1, 1'b0, 16'h0000},
        '{16'h8000, 1'b0, 1'b0, 16'h0000},
        '{16'h0002, 1'b0, 1'b0, 16'h0000},
        '{16'h7FFE, 1'b1, 1'b0, 16'h0000},
        '{16'hAAAA, 1'b0, 1'b0, 16'h0000},
        '{16'h5555, 1'b1, 1'b0, 16'h0000}
    };

    // Predictor state and the words still owed by the block.
    value_t       held_set [$];
    sorted_word_t burst [$];
    sorted_word_t pending_words [$];

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int sets_closed     = 0;
    int dropped_words   = 0;
    int stall_cycles    = 0;
    int tx_idle_pct     = 0;
    bit quiet           = 1'b0;
    bit hold_req        = 1'b0;

    // Clock: 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Takes one accepted word into the held set; on the closing word the set
    // is ordered by (low bit, value) into burst and the set is emptied.
    function automatic void absorb_word(input logic [DATA_W-1:0] raw, input logic last);
        value_t v;
        value_t t;
        int     i;
        int     j;
        v = raw[VALUE_WIDTH-1:0];
        burst.delete();
        // A full store drops the word, even a closing one.
        if (held_set.size() < MAX_ELEMENTS)
            held_set.push_back(v);
        else
            dropped_words++;
        if (last)
        begin
            // Insertion sort: evens rank ahead of odds, then by value.
            for (i = 1; i < held_set.size(); i++)
            begin
                t = held_set[i];
                j = i;
                while (j > 0 && {held_set[j-1][0], held_set[j-1]} > {t[0], t})
                begin
                    held_set[j] = held_set[j-1];
                    j--;
                end
                held_set[j] = t;
            end
            for (i = 0; i < held_set.size(); i++)
                burst.push_back('{held_set[i], i == held_set.size() - 1});
            held_set.delete();
            sets_closed++;
        end
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       pick_idle_pct = 0;
            1:       pick_idle_pct = 15;
            default: pick_idle_pct = 40;
        endcase
    endfunction

    // Random element: many small values for duplicates, some corner values.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1:    pick_value = DATA_W'($urandom_range(0, 7));
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       pick_value = '0;
                    1:       pick_value = '1;
                    2:       pick_value = {{(DATA_W-1){1'b1}}, 1'b0};
                    default: pick_value = DATA_W'(1);
                endcase
            end
            default: pick_value = DATA_W'($urandom);
        endcase
    endfunction

    // Offers one word and holds it until accepted, then records what it owes.
    task automatic send_word(input logic [DATA_W-1:0] raw, input logic last,
                             input logic typed, input value_t want);
        in_ch.valid   <= 1'b1;
        in_ch.value   <= raw;
        in_ch.is_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
        absorb_word(raw, last);
        if (typed)
            pending_words.push_back('{want, 1'b1});
        else
            foreach (burst[k])
                pending_words.push_back(burst[k]);
    endtask

    // Random sender gap after an accepted word.
    task automatic pause_sender();
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Stimulus: reset, directed table, random sets, then wait for the drain.
    initial
    begin
        int r;
        int w;
        int set_no;
        int set_len;
        int rand_sent;
        in_ch.valid   <= 1'b0;
        in_ch.value   <= '0;
        in_ch.is_last <= 1'b0;
        rst_n         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 25;
        for (r = 0; r < DIR_ROWS; r++)
        begin
            send_word(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].want);
            pause_sender();
        end

        // The first sets fill the store exactly, then overflow it, so the
        // closing word of an overflowing set is dropped but the set still drains.
        set_no    = 0;
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            case (set_no)
                0:       set_len = MAX_ELEMENTS;
                1:       set_len = MAX_ELEMENTS + 1;
                2:       set_len = MAX_ELEMENTS + 3;
                default: set_len = ($urandom_range(0, 7) == 0) ?
                                   $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 6) :
                                   $urandom_range(1, 10);
            endcase
            // The final set is cut short so the word total stays on budget.
            if (set_len > RANDOM_ITEMS - rand_sent)
                set_len = RANDOM_ITEMS - rand_sent;
            tx_idle_pct = pick_idle_pct();
            for (w = 0; w < set_len; w++)
            begin
                if (rand_sent >= RANDOM_ITEMS - QUIET_TAIL)
                    quiet = 1'b1;
                send_word(pick_value(), w == set_len - 1, 1'b0, '0);
                rand_sent++;
                pause_sender();
            end
            // Back-pressure the output while the next set keeps coming.
            if (set_no == 0)
                hold_req = 1'b1;
            set_no++;
        end
        in_ch.valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d sets (%0d dropped by a full store), checked %0d results.",
                 words_sent, sets_closed, dropped_words, results_checked);
        if (errors == 0)
            $display("even_first_sorter_top verification clean");
        else
            $display("even_first_sorter_top verification failed");
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off on request, none at the end.
    initial
    begin
        int rx_idle_pct;
        int rx_phase;
        rx_idle_pct = 10;
        rx_phase    = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < rx_idle_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
            rx_phase++;
            if (rx_phase % 64 == 0)
                rx_idle_pct = pick_idle_pct();
        end
    end

    // Result checker: each accepted word against the oldest owed word.
    always @(posedge clk)
    begin
        sorted_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_checked++;
            if (pending_words.size() == 0)
            begin
                errors++;
                $error("unexpected result word: value_res %0h is_last_res %0b",
                       out_ch.value_res, out_ch.is_last_res);
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_ch.value_res !== DATA_W'(want.value))
                begin
                    errors++;
                    $error("value_res: expected %0h, got %0h", want.value, out_ch.value_res);
                end
                if (out_ch.is_last_res !== want.last)
                begin
                    errors++;
                    $error("is_last_res: expected %0b, got %0b", want.last, out_ch.is_last_res);
                end
            end
        end
    end

    // Cycles since the last word moved on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog: a long stretch with no traffic ends the run.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Timed out with %0d result words still owed.", pending_words.size());
        $display("even_first_sorter_top verification failed");
        $finish;
    end

endmodule

// ===== even_first_sorter_top.f =====
rtl/efs_pkg.sv
rtl/efs_in_if.sv
rtl/efs_out_if.sv
rtl/efs_front.sv
rtl/efs_queue.sv
rtl/efs_back.sv
rtl/even_first_sorter_top.sv
bench/even_first_sorter_top_tb.sv
